// ===== rtl/kmds_pkg.sv =====
// kmds_pkg: payload types and fixed constants of the key matrix debounce scanner
// no dependencies; imported by key_matrix_debounce_scanner_unit
`default_nettype none

package kmds_pkg;

    localparam int ROW_W    = 2;
    localparam int SAMPLE_W = 12;
    localparam int COL_W    = 4;
    localparam int CNT_W    = 8;

    localparam logic [CNT_W-1:0] LOCKOUT_RESET = 8'd3;

    typedef struct packed {
        logic [ROW_W-1:0]    row_index;
        logic [SAMPLE_W-1:0] column_sample;
    } scan_t;

    typedef struct packed {
        logic [ROW_W-1:0] event_row;
        logic [COL_W-1:0] event_column;
        logic             was_pressed;
        logic             is_pressed;
        logic             last_event;
    } key_event_t;

endpackage

`default_nettype wire

// ===== rtl/key_matrix_debounce_scanner_unit.sv =====
// key matrix debounce scanner: per-key lockout debounce and key event emitter
// depends on kmds_pkg for payload types and constants
// the scan lands in the holding register; row state and first event register on its load
// throughput: one row scan per cycle when it reports no key, else held until its last key
// while evt_ready is high the emitter sends one key per cycle, lowest active column first
// reset: async active low; debounced states, lockout counters cleared, lockout register to 3
`default_nettype none

module key_matrix_debounce_scanner_unit #(
    parameter int ROWS    = 4,
    parameter int COLUMNS = 12
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          scan_valid,
    output logic                         scan_ready,
    input  kmds_pkg::scan_t              scan_item,
    output logic                         evt_valid,
    input  wire                          evt_ready,
    output kmds_pkg::key_event_t         evt_item,
    input  wire                          cfg_we,
    input  wire  [kmds_pkg::CNT_W-1:0]   cfg_data
);
    import kmds_pkg::*;

    localparam int RA_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    // configuration
    logic [CNT_W-1:0] lockout_reg;

    // input holding register
    logic  hold_valid_reg;
    scan_t hold_reg;

    // per-row state
    logic [COLUMNS-1:0] keys_reg [ROWS];
    logic [CNT_W-1:0]   cnt_reg  [ROWS][COLUMNS];

    // emitter registers
    logic               emit_valid_reg, emit_valid_next;
    logic [ROW_W-1:0]   emit_row_reg;
    logic [COLUMNS-1:0] emit_before_reg;
    logic [COLUMNS-1:0] emit_after_reg;
    logic [COLUMNS-1:0] emit_mask_reg, emit_mask_next;

    logic               load;
    logic               emit_free;
    logic               emit_done;
    logic               row_ok;
    logic [3:0]         row_ext;
    logic [RA_W-1:0]    row_addr;
    logic [COLUMNS-1:0] sample;
    logic [COLUMNS-1:0] prev_keys;
    logic [COLUMNS-1:0] open_bits;
    logic [COLUMNS-1:0] after;
    logic [COLUMNS-1:0] changed;
    logic [COLUMNS-1:0] active;
    logic [CNT_W-1:0]   cnt_next [COLUMNS];
    logic [COLUMNS-1:0] lowest;
    logic [COL_W-1:0]   low_idx;
    logic               low_last;

    // sample bits beyond the field width are never pressed
    for (genvar g = 0; g < COLUMNS; g++)
    begin : g_sample
        if (g < SAMPLE_W)
        begin : g_in
            assign sample[g] = hold_reg.column_sample[g];
        end
        else
        begin : g_zero
            assign sample[g] = 1'b0;
        end
    end

    assign row_ext  = {2'b00, hold_reg.row_index};
    assign row_addr = row_ext[RA_W-1:0];
    assign row_ok   = ({3'b000, hold_reg.row_index} < 5'(ROWS));

    always_comb
    begin
        prev_keys = keys_reg[row_addr];
        for (int c = 0; c < COLUMNS; c++)
        begin
            open_bits[c] = (cnt_reg[row_addr][c] == '0);
        end
        after   = (sample & open_bits) | (prev_keys & ~open_bits);
        changed = after ^ prev_keys;
        active  = prev_keys | after;
        for (int c = 0; c < COLUMNS; c++)
        begin
            if (changed[c])
                cnt_next[c] = lockout_reg;
            else if (!open_bits[c])
                cnt_next[c] = cnt_reg[row_addr][c] - 1'b1;
            else
                cnt_next[c] = cnt_reg[row_addr][c];
        end
    end

    // lowest pending column of the emitter
    always_comb
    begin
        lowest   = emit_mask_reg & (~emit_mask_reg + 1'b1);
        low_last = ((emit_mask_reg & ~lowest) == '0);
        low_idx  = '0;
        for (int c = 0; c < COLUMNS; c++)
        begin
            if (lowest[c])
                low_idx = low_idx | COL_W'(c);
        end
    end

    assign emit_done  = emit_valid_reg & evt_ready & low_last;
    assign emit_free  = !emit_valid_reg | emit_done;
    assign load       = hold_valid_reg & emit_free;
    assign scan_ready = !hold_valid_reg | load;

    always_comb
    begin
        emit_valid_next = emit_valid_reg;
        emit_mask_next  = emit_mask_reg;
        if (load)
        begin
            emit_valid_next = row_ok && (active != '0);
            emit_mask_next  = active;
        end
        else if (emit_valid_reg && evt_ready)
        begin
            emit_valid_next = !low_last;
            emit_mask_next  = emit_mask_reg & ~lowest;
        end
    end

    always_comb
    begin
        evt_valid             = emit_valid_reg;
        evt_item.event_row    = emit_row_reg;
        evt_item.event_column = low_idx;
        evt_item.was_pressed  = |(emit_before_reg & lowest);
        evt_item.is_pressed   = |(emit_after_reg & lowest);
        evt_item.last_event   = low_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg    <= LOCKOUT_RESET;
            hold_valid_reg <= 1'b0;
            emit_valid_reg <= 1'b0;
            for (int r = 0; r < ROWS; r++)
            begin
                keys_reg[r] <= '0;
                for (int c = 0; c < COLUMNS; c++)
                begin
                    cnt_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_we)
                lockout_reg <= cfg_data;
            if (scan_ready)
                hold_valid_reg <= scan_valid;
            emit_valid_reg <= emit_valid_next;
            if (load && row_ok)
            begin
                keys_reg[row_addr] <= after;
                for (int c = 0; c < COLUMNS; c++)
                begin
                    cnt_reg[row_addr][c] <= cnt_next[c];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (scan_valid && scan_ready)
            hold_reg <= scan_item;
        emit_mask_reg <= emit_mask_next;
        if (load)
        begin
            emit_row_reg    <= hold_reg.row_index;
            emit_before_reg <= prev_keys;
            emit_after_reg  <= after;
        end
    end

    // emitter never shows an empty mask
    a_mask_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid_reg |-> (emit_mask_reg != '0))
        else $error("emitter valid with empty column mask");

    a_column_range : assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> (evt_item.event_column < COLUMNS))
        else $error("event column outside the matrix");

    a_hold_blocks : assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !emit_free) |-> !scan_ready)
        else $error("scan taken while holding register is stuck");

    a_last_drains : assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt_ready && evt_item.last_event && !load) |=> !evt_valid)
        else $error("events continue after last event transaction");

endmodule

`default_nettype wire
